/* hdl/elb_pkg.sv */
// ============================================================================
// elb_pkg: shared types and constants for the endpoint load balancer
// Request codes, balancing modes and default sizes used by the controller,
// datapath and top level.
package elb_pkg;

  localparam int unsigned MaxEndpointsDef  = 128;
  localparam int unsigned ConnCountBitsDef = 16;

  localparam int unsigned ReqW      = 3;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned SelIdxW   = 7;
  localparam int unsigned InUseW    = 8;
  localparam int unsigned ModeW     = 2;

  localparam logic [ReqW-1:0] REQ_ADD    = 3'd0;
  localparam logic [ReqW-1:0] REQ_REMOVE = 3'd1;
  localparam logic [ReqW-1:0] REQ_SELECT = 3'd2;
  localparam logic [ReqW-1:0] REQ_CONN   = 3'd3;
  localparam logic [ReqW-1:0] REQ_DISC   = 3'd4;
  localparam logic [ReqW-1:0] REQ_CLEAR  = 3'd5;

  localparam logic [ModeW-1:0] MODE_RR    = 2'd0;
  localparam logic [ModeW-1:0] MODE_LEAST = 2'd1;
  localparam logic [ModeW-1:0] MODE_HASH  = 2'd2;
  localparam logic [ModeW-1:0] MODE_FIRST = 2'd3;

  // Commands from the controller to the datapath, one strobe each.
  typedef struct packed {
    logic load;       // capture the request
    logic scan_init;  // clear scan index
    logic scan_step;  // compare entry at scan index, advance
    logic div_init;   // start remainder computation
    logic div_step;   // one restoring step
    logic shift_step; // move entry idx+1 down to idx
    logic append;     // write new key at count
    logic cnt_read;   // read count at found entry
    logic cnt_upd;    // update count at found entry
    logic sel_read;   // read key at chosen index
    logic finish;     // build result
  } elb_cmd_t;

  typedef struct packed {
    logic scan_done;  // scan index reached entry count
    logic found;      // key match seen
    logic div_done;
    logic shift_done;
  } elb_sts_t;

endpackage

/* hdl/elb_stream_if.sv */
// ============================================================================
// elb_stream_if: valid/ready channel
// Carries one payload with a source and a sink modport.
// ============================================================================
interface elb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/elb_ctrl.sv */
// ============================================================================
// elb_ctrl: request sequencer
// Walks each request through scan, remainder, shift, count update, read and result steps.
// ============================================================================
module elb_ctrl
  import elb_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic [ReqW-1:0] req,
  input  logic [ModeW-1:0] mode,
  input  logic            empty,
  input  logic            full,
  input  elb_sts_t        sts,
  input  logic            out_free,
  output logic            busy,
  output elb_cmd_t        cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_ACT   = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;
  localparam logic [2:0] ST_UPD   = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          cmd.scan_init = 1'b1;
          cmd.div_init = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Selects scan only for least connections; round robin and hash
        // need the remainder, the first-entry mode reads entry 0 at once.
        if (req == REQ_SELECT) begin
          if (empty) state_nxt = ST_DONE;
          else if (mode == MODE_LEAST) begin
            if (sts.scan_done) state_nxt = ST_READ;
            else cmd.scan_step = 1'b1;
          end else if (mode == MODE_FIRST) state_nxt = ST_READ;
          else state_nxt = ST_DIV;
        end else if (req == REQ_ADD && full) begin
          state_nxt = ST_DONE;
        end else if (req == REQ_ADD || req == REQ_REMOVE || req == REQ_CONN ||
                     req == REQ_DISC) begin
          if (sts.scan_done || sts.found) state_nxt = ST_ACT;
          else cmd.scan_step = 1'b1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_READ;
        else cmd.div_step = 1'b1;
      end
      ST_ACT: begin
        if (req == REQ_ADD) begin
          if (!sts.found) cmd.append = 1'b1;
          state_nxt = ST_DONE;
        end else if (req == REQ_REMOVE) begin
          state_nxt = sts.found ? ST_SHIFT : ST_DONE;
        end else if (sts.found) begin
          cmd.cnt_read = 1'b1;
          state_nxt = ST_UPD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_UPD: begin
        cmd.cnt_upd = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_SHIFT: begin
        // The step stays on through the last write; the datapath drops the
        // entry count on the cycle that reports completion.
        cmd.shift_step = 1'b1;
        if (sts.shift_done) state_nxt = ST_DONE;
      end
      ST_READ: begin
        cmd.sel_read = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* hdl/elb_datapath.sv */
// ============================================================================
// elb_datapath: endpoint table and arithmetic
// Key and count memories, scan index, serial remainder unit and result fields.
// ============================================================================
module elb_datapath
  import elb_pkg::*;
#(
  parameter int unsigned MAX_ENDPOINTS   = MaxEndpointsDef,
  parameter int unsigned CONN_COUNT_BITS = ConnCountBitsDef
)(
  input  logic               clk,
  input  logic               rst_n,
  input  elb_cmd_t           cmd,
  input  logic [ReqW-1:0]    in_req,
  input  logic [KeyW-1:0]    in_key,
  input  logic [KeyW-1:0]    in_hash,
  input  logic               in_has_client,
  input  logic [ModeW-1:0]   mode,
  output logic [ReqW-1:0]    req,
  output logic               empty,
  output logic               full,
  output elb_sts_t           sts,
  output logic               res_status,
  output logic [SelIdxW-1:0] res_index,
  output logic [KeyW-1:0]    res_key,
  output logic [InUseW-1:0]  res_in_use
);

  localparam int unsigned IdxW = $clog2(MAX_ENDPOINTS);
  localparam int unsigned CntW = $clog2(MAX_ENDPOINTS + 1);
  localparam logic [CONN_COUNT_BITS-1:0] CountMax = '1;

  // Both tables share one read address and registered read data. The scan and
  // the removal shift are pipelined around that read, one entry per cycle.
  logic [KeyW-1:0]            keys_m [MAX_ENDPOINTS];
  logic [CONN_COUNT_BITS-1:0] cnts_m [MAX_ENDPOINTS];

  logic [CntW-1:0]  count_r;
  logic [KeyW-1:0]  rot_r;
  logic [ReqW-1:0]  req_r;
  logic [KeyW-1:0]  key_r;
  logic             was_full_r;
  logic [CntW-1:0]  scan_r;
  logic             found_r;
  logic [IdxW-1:0]  pos_r;
  logic [CONN_COUNT_BITS-1:0] best_r;
  logic [IdxW-1:0]  sel_r;
  logic [KeyW-1:0]  rem_r;
  logic [KeyW-1:0]  quo_r;
  logic [5:0]       bit_r;
  logic [KeyW-1:0]  rd_key_r;
  logic [CONN_COUNT_BITS-1:0] rd_cnt_r;
  logic             cmp_v_r;
  logic [IdxW-1:0]  cmp_idx_r;
  logic             mv_v_r;
  logic [IdxW-1:0]  mv_idx_r;

  logic [IdxW-1:0]  scan_idx;
  logic [IdxW-1:0]  nxt_idx;
  logic [KeyW:0]    rem_sh;
  logic             scan_go;
  logic             shift_end;
  logic             shift_go;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic [IdxW-1:0]  pick_idx;
  logic             err;

  assign scan_idx = scan_r[IdxW-1:0];
  assign nxt_idx  = pos_r + IdxW'(1);

  assign req   = req_r;
  assign empty = (count_r == '0);
  assign full  = (count_r >= CntW'(MAX_ENDPOINTS));

  // A scan step reads only while entries remain; the compare follows in the
  // next cycle on the registered read data.
  assign scan_go   = cmd.scan_step && (scan_r < count_r);
  assign shift_end = (CntW'(pos_r) + CntW'(1) >= count_r);
  assign shift_go  = cmd.shift_step && !shift_end;

  assign sts.scan_done  = !(scan_r < count_r) && !cmp_v_r;
  assign sts.found      = found_r;
  assign sts.div_done   = (bit_r == 6'd0);
  assign sts.shift_done = shift_end && !mv_v_r;

  assign rem_sh = {rem_r, quo_r[KeyW-1]};

  // Round robin and hash take the remainder; the other modes pick here.
  always_comb begin
    case (mode)
      MODE_LEAST: pick_idx = sel_r;
      MODE_FIRST: pick_idx = '0;
      default:    pick_idx = rem_r[IdxW-1:0];
    endcase
  end

  // Without a scan, shift or select read, the port follows the found entry.
  assign rd_en = scan_go || shift_go || cmd.cnt_read || cmd.sel_read;
  always_comb begin
    rd_addr = pos_r;
    if (scan_go) rd_addr = scan_idx;
    else if (shift_go) rd_addr = nxt_idx;
    else if (cmd.sel_read) rd_addr = pick_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rot_r   <= '0;
      cmp_v_r <= 1'b0;
      mv_v_r  <= 1'b0;
    end else begin
      cmp_v_r <= scan_go;
      mv_v_r  <= shift_go;
      if (cmd.append) count_r <= count_r + CntW'(1);
      if (cmd.shift_step && sts.shift_done) count_r <= count_r - CntW'(1);
      if (cmd.load && in_req == REQ_CLEAR) count_r <= '0;
      if (cmd.load && in_req == REQ_SELECT && count_r != '0 &&
          (mode == MODE_RR || (mode == MODE_HASH && !in_has_client)))
        rot_r <= rot_r + KeyW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r      <= in_req;
      key_r      <= in_key;
      was_full_r <= full;
      found_r    <= 1'b0;
      pos_r      <= '0;
      sel_r      <= '0;
      best_r     <= '1;
      // Round robin reuses the remainder unit on the old pointer value.
      quo_r      <= (mode == MODE_HASH && in_has_client) ? in_hash : rot_r;
    end
    if (cmd.scan_init) scan_r <= '0;
    if (scan_go) scan_r <= scan_r + CntW'(1);
    cmp_idx_r <= scan_idx;
    if (cmp_v_r) begin
      if (req_r == REQ_SELECT) begin
        if (cmp_idx_r == '0 || rd_cnt_r < best_r) begin
          best_r <= rd_cnt_r;
          sel_r  <= cmp_idx_r;
        end
      end else if (!found_r && rd_key_r == key_r) begin
        found_r <= 1'b1;
        pos_r   <= cmp_idx_r;
      end
    end
    if (cmd.div_init) begin
      bit_r <= 6'(KeyW);
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      bit_r <= bit_r - 6'd1;
      if (rem_sh >= {{(KeyW+1-CntW){1'b0}}, count_r}) begin
        rem_r <= KeyW'(rem_sh - {{(KeyW+1-CntW){1'b0}}, count_r});
      end else begin
        rem_r <= rem_sh[KeyW-1:0];
      end
      quo_r <= {quo_r[KeyW-2:0], 1'b0};
    end
    // Shift: read entry pos+1 now, write it to pos on the next cycle.
    if (shift_go) pos_r <= nxt_idx;
    mv_idx_r <= pos_r;
    if (mv_v_r) begin
      keys_m[mv_idx_r] <= rd_key_r;
      cnts_m[mv_idx_r] <= rd_cnt_r;
    end
    if (cmd.append) begin
      keys_m[count_r[IdxW-1:0]] <= key_r;
      cnts_m[count_r[IdxW-1:0]] <= '0;
    end
    if (cmd.cnt_upd) begin
      if (req_r == REQ_CONN) begin
        if (rd_cnt_r != CountMax)
          cnts_m[pos_r] <= rd_cnt_r + CONN_COUNT_BITS'(1);
      end else if (rd_cnt_r != '0) begin
        cnts_m[pos_r] <= rd_cnt_r - CONN_COUNT_BITS'(1);
      end
    end
    if (rd_en) begin
      rd_key_r <= keys_m[rd_addr];
      rd_cnt_r <= cnts_m[rd_addr];
    end
    if (cmd.sel_read) sel_r <= pick_idx;
  end

  always_comb begin
    err = 1'b0;
    case (req_r)
      REQ_ADD:    err = was_full_r;
      REQ_REMOVE, REQ_CONN, REQ_DISC: err = !found_r;
      REQ_SELECT: err = empty;
      REQ_CLEAR:  err = 1'b0;
      default:    err = 1'b1;
    endcase
  end

  assign res_status = err;
  assign res_index  = (req_r == REQ_SELECT && !empty) ? SelIdxW'(sel_r) : '0;
  assign res_key    = (req_r == REQ_SELECT && !empty) ? rd_key_r : '0;
  assign res_in_use = InUseW'(count_r);

endmodule

/* hdl/endpoint_load_balancer.sv */
// ============================================================================
// endpoint_load_balancer: endpoint table with selection policies
// Top level joining the request sequencer and the table datapath.
// ============================================================================
// One request is handled at a time. After the accepting edge a request walks
// the table as it needs: a key search or the least-connections scan reads
// one entry per cycle through the registered read port, a removal moves one
// later entry down per cycle, and the remainder for round robin and client
// hash takes 32 steps. A finished request waits to enter the output register
// while the previous result still waits on out_ch.ready. The input is ready
// again once the result has moved into the output register, so the next
// request can be accepted while that result waits for its transfer.
module endpoint_load_balancer
  import elb_pkg::*;
#(
  parameter int unsigned MAX_ENDPOINTS   = MaxEndpointsDef,
  parameter int unsigned CONN_COUNT_BITS = ConnCountBitsDef
)(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ModeW-1:0]  cfg_wdata,
  elb_stream_if.sink        in_ch,
  elb_stream_if.source      out_ch
);

  logic [ModeW-1:0] mode_r;
  logic             busy;
  logic             in_fire;
  elb_cmd_t         cmd;
  elb_sts_t         sts;
  logic [ReqW-1:0]  req;
  logic             empty, full;
  logic             res_status;
  logic [SelIdxW-1:0] res_index;
  logic [KeyW-1:0]  res_key;
  logic [InUseW-1:0] res_in_use;
  logic             ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= MODE_RR;
    else if (cfg_we) mode_r <= cfg_wdata;
  end

  assign in_ch.ready = !busy;
  assign in_fire     = in_ch.valid && in_ch.ready;

  elb_ctrl u_ctrl (
    .clk, .rst_n, .in_fire,
    .req, .mode(mode_r), .empty, .full, .sts,
    .out_free(!ov_r || out_ch.ready),
    .busy, .cmd
  );

  elb_datapath #(
    .MAX_ENDPOINTS(MAX_ENDPOINTS), .CONN_COUNT_BITS(CONN_COUNT_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd,
    .in_req(in_ch.data.req_type), .in_key(in_ch.data.endpoint_key),
    .in_hash(in_ch.data.client_hash), .in_has_client(in_ch.data.has_client),
    .mode(mode_r), .req, .empty, .full, .sts,
    .res_status, .res_index, .res_key, .res_in_use
  );

  // Output register: holds a finished result until it is transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.finish) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ch.data.status         <= res_status;
      out_ch.data.selected_index <= res_index;
      out_ch.data.selected_key   <= res_key;
      out_ch.data.entries_in_use <= res_in_use;
    end
  end

  assign out_ch.valid = ov_r;

  // A request is never taken while one is in flight.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready) else $error("request accepted while busy");

  // A result is only produced for a request that was accepted.
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> busy) else $error("result without request");

  // The table never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.entries_in_use <= InUseW'(MAX_ENDPOINTS)))
    else $error("entry count overflow");

endmodule
